// ----- design/mipsdec_pkg.sv -----
// shared types and constants for the mips32 instruction decoder
`timescale 1ns / 1ps

package mipsdec_pkg;

    // primary opcodes
    localparam logic [5:0] OPC_SPECIAL  = 6'h00;
    localparam logic [5:0] OPC_REGIMM   = 6'h01;
    localparam logic [5:0] OPC_J        = 6'h02;
    localparam logic [5:0] OPC_JAL      = 6'h03;
    localparam logic [5:0] OPC_SPECIAL2 = 6'h1c;

    localparam logic [31:0] SYSCALL_WORD = 32'd12;

    // dense operation numbers
    localparam logic [6:0] OP_NONE    = 7'd0;
    localparam logic [6:0] OP_SYSCALL = 7'd1;
    localparam logic [6:0] OP_J       = 7'd41;
    localparam logic [6:0] OP_JAL     = 7'd42;

    // one decoded instruction
    typedef struct packed {
        logic [6:0]  operation;
        logic [4:0]  source_reg;
        logic [4:0]  target_reg;
        logic [4:0]  dest_reg;
        logic [4:0]  shift_amount;
        logic [15:0] immediate;
        logic [25:0] jump_target;
    } t_decoded;

endpackage

// ----- design/mipsdec_decode.sv -----
// combinational decode of one instruction word into operation and fields
`timescale 1ns / 1ps

module mipsdec_decode (
    input  logic [31:0]           i_word,
    output mipsdec_pkg::t_decoded o_dec
);
    import mipsdec_pkg::*;

    logic [5:0]  w_opc;
    logic [5:0]  w_fn;
    logic [4:0]  w_rt;
    logic [6:0]  w_special_op;
    logic [6:0]  w_special2_op;
    logic [6:0]  w_regimm_op;
    logic [6:0]  w_imm_op;
    t_decoded    w_raw;

    assign w_opc = i_word[31:26];
    assign w_fn  = i_word[5:0];
    assign w_rt  = i_word[20:16];

    // register format, funct table
    always_comb begin
        case (w_fn)
            6'h20: w_special_op = 7'd9;
            6'h21: w_special_op = 7'd10;
            6'h24: w_special_op = 7'd11;
            6'h1a: w_special_op = 7'd12;
            6'h1b: w_special_op = 7'd13;
            6'h18: w_special_op = 7'd14;
            6'h19: w_special_op = 7'd15;
            6'h27: w_special_op = 7'd16;
            6'h25: w_special_op = 7'd17;
            6'h04: w_special_op = 7'd18;
            6'h07: w_special_op = 7'd19;
            6'h06: w_special_op = 7'd20;
            6'h22: w_special_op = 7'd21;
            6'h23: w_special_op = 7'd22;
            6'h26: w_special_op = 7'd23;
            6'h2a: w_special_op = 7'd24;
            6'h2b: w_special_op = 7'd25;
            6'h09: w_special_op = 7'd26;
            6'h08: w_special_op = 7'd27;
            6'h34: w_special_op = 7'd28;
            6'h36: w_special_op = 7'd29;
            6'h32: w_special_op = 7'd30;
            6'h33: w_special_op = 7'd31;
            6'h30: w_special_op = 7'd32;
            6'h31: w_special_op = 7'd33;
            6'h10: w_special_op = 7'd34;
            6'h12: w_special_op = 7'd35;
            6'h11: w_special_op = 7'd36;
            6'h13: w_special_op = 7'd37;
            6'h00: w_special_op = 7'd38;
            6'h03: w_special_op = 7'd39;
            6'h02: w_special_op = 7'd40;
            default: w_special_op = OP_NONE;
        endcase
    end

    // special2 group
    always_comb begin
        case (w_fn)
            6'h21: w_special2_op = 7'd2;
            6'h20: w_special2_op = 7'd3;
            6'h02: w_special2_op = 7'd4;
            6'h00: w_special2_op = 7'd5;
            6'h01: w_special2_op = 7'd6;
            6'h04: w_special2_op = 7'd7;
            6'h05: w_special2_op = 7'd8;
            default: w_special2_op = OP_NONE;
        endcase
    end

    // regimm, keyed by rt
    always_comb begin
        case (w_rt)
            5'h01: w_regimm_op = 7'd55;
            5'h11: w_regimm_op = 7'd56;
            5'h10: w_regimm_op = 7'd57;
            5'h00: w_regimm_op = 7'd58;
            5'h0c: w_regimm_op = 7'd59;
            5'h0e: w_regimm_op = 7'd60;
            5'h08: w_regimm_op = 7'd61;
            5'h09: w_regimm_op = 7'd62;
            5'h0a: w_regimm_op = 7'd63;
            5'h0b: w_regimm_op = 7'd64;
            default: w_regimm_op = OP_NONE;
        endcase
    end

    // immediate format, keyed by primary opcode
    always_comb begin
        case (w_opc)
            6'h08: w_imm_op = 7'd43;
            6'h09: w_imm_op = 7'd44;
            6'h0c: w_imm_op = 7'd45;
            6'h0d: w_imm_op = 7'd46;
            6'h0e: w_imm_op = 7'd47;
            6'h0f: w_imm_op = 7'd48;
            6'h0a: w_imm_op = 7'd49;
            6'h0b: w_imm_op = 7'd50;
            6'h04: w_imm_op = 7'd51;
            6'h07: w_imm_op = 7'd52;
            6'h06: w_imm_op = 7'd53;
            6'h05: w_imm_op = 7'd54;
            6'h20: w_imm_op = 7'd65;
            6'h24: w_imm_op = 7'd66;
            6'h21: w_imm_op = 7'd67;
            6'h25: w_imm_op = 7'd68;
            6'h23: w_imm_op = 7'd69;
            6'h22: w_imm_op = 7'd70;
            6'h26: w_imm_op = 7'd71;
            6'h30: w_imm_op = 7'd72;
            6'h28: w_imm_op = 7'd73;
            6'h29: w_imm_op = 7'd74;
            6'h2b: w_imm_op = 7'd75;
            6'h2a: w_imm_op = 7'd76;
            6'h2e: w_imm_op = 7'd77;
            6'h38: w_imm_op = 7'd78;
            default: w_imm_op = OP_NONE;
        endcase
    end

    // format select
    always_comb begin
        w_raw = '0;
        if (i_word == SYSCALL_WORD) begin
            w_raw.operation = OP_SYSCALL;
        end else if (w_opc == OPC_SPECIAL || w_opc == OPC_SPECIAL2) begin
            w_raw.operation    = (w_opc == OPC_SPECIAL2) ? w_special2_op : w_special_op;
            w_raw.source_reg   = i_word[25:21];
            w_raw.target_reg   = i_word[20:16];
            w_raw.dest_reg     = i_word[15:11];
            w_raw.shift_amount = i_word[10:6];
        end else if (w_opc == OPC_J || w_opc == OPC_JAL) begin
            w_raw.operation   = (w_opc == OPC_J) ? OP_J : OP_JAL;
            w_raw.jump_target = i_word[25:0];
        end else begin
            w_raw.operation  = (w_opc == OPC_REGIMM) ? w_regimm_op : w_imm_op;
            w_raw.source_reg = i_word[25:21];
            w_raw.target_reg = i_word[20:16];
            w_raw.immediate  = i_word[15:0];
        end
    end

    // unrecognized words report nothing
    assign o_dec = (w_raw.operation == OP_NONE) ? '0 : w_raw;

endmodule

// ----- design/mips32_instruction_decoder.sv -----
// top level: mips32 instruction decoder with input and result registers
// path: an accepted request loads the input reg, then its decode loads the result reg
// and raises result valid; a stall on the result side holds it in the input reg
// throughput: 1 request per cycle; both stages advance when the next one frees
// reset: i_rst_n synchronous active low, clears both stage valid flags only
// no configuration, no state beyond the pipeline
`timescale 1ns / 1ps

module mips32_instruction_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_instruction,
    // result side
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [6:0]  o_operation,
    output logic [4:0]  o_source_reg,
    output logic [4:0]  o_target_reg,
    output logic [4:0]  o_dest_reg,
    output logic [4:0]  o_shift_amount,
    output logic [15:0] o_immediate,
    output logic [25:0] o_jump_target
);
    import mipsdec_pkg::*;

    // input stage
    logic        r_in_valid;
    logic [31:0] r_in_word;
    // result stage
    logic        r_out_valid;
    t_decoded    r_out;
    t_decoded    w_dec;
    logic        w_out_free;

    // result stage can load when empty or being drained this cycle
    assign w_out_free = !r_out_valid || i_out_ready;
    // input stage can load when empty or moving forward this cycle
    assign o_in_ready = !r_in_valid || w_out_free;

    mipsdec_decode u_decode (
        .i_word (r_in_word),
        .o_dec  (w_dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_instruction;
        end
        if (w_out_free && r_in_valid) begin
            r_out <= w_dec;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_operation    = r_out.operation;
    assign o_source_reg   = r_out.source_reg;
    assign o_target_reg   = r_out.target_reg;
    assign o_dest_reg     = r_out.dest_reg;
    assign o_shift_amount = r_out.shift_amount;
    assign o_immediate    = r_out.immediate;
    assign o_jump_target  = r_out.jump_target;

    // unrecognized result carries all-zero fields
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.operation == OP_NONE) |->
            (r_out.source_reg == 5'd0 && r_out.target_reg == 5'd0 &&
             r_out.dest_reg == 5'd0 && r_out.shift_amount == 5'd0 &&
             r_out.immediate == 16'd0 && r_out.jump_target == 26'd0))
        else $error("unrecognized result with nonzero fields");

    // jump results only carry the target
    a_jump_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.operation == OP_J || r_out.operation == OP_JAL)) |->
            (r_out.source_reg == 5'd0 && r_out.target_reg == 5'd0 &&
             r_out.immediate == 16'd0))
        else $error("jump result with register or immediate fields");

    // a held input request is not dropped while the result stage is stalled
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_free) |=> (r_in_valid && $stable(r_in_word)))
        else $error("input stage lost a request under stall");

    // an accepted request occupies the input stage next cycle
    a_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_in_valid)
        else $error("accepted request not captured");

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("result changed while stalled");

endmodule
